@@ rtl/dda3_pkg.sv @@
// ----------------------------------------------------------------------------
// dda3_pkg
// Shared types and constants for the three-axis DDA step generator.
// ----------------------------------------------------------------------------
package dda3_pkg;

    localparam int AXES    = 3;
    localparam int COUNT_W = 32;
    localparam int LEVEL_W = 3;
    localparam int EVENT_W = 30;
    localparam int ERR_W   = 32;
    localparam int INC_W   = 31;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd3;
    localparam logic [EVENT_W-1:0] EVENT_LIMIT = 30'h3FFF_FFFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [EVENT_W-1:0] event_t;

    typedef struct packed {
        logic             ok;
        logic [EVENT_W-1:0] total;
    } move_info_t;

    typedef struct packed {
        logic               load;
        logic               tick;
        logic [EVENT_W-1:0] total;
        logic [INC_W-1:0]   wrap;
    } axis_ctl_t;

endpackage

@@ rtl/dda3_move.sv @@
// ----------------------------------------------------------------------------
// dda3_move
// Checks a start transaction and computes the total event count of the move.
// ----------------------------------------------------------------------------
module dda3_move (
    input  dda3_pkg::count_t              steps [dda3_pkg::AXES],
    input  logic [dda3_pkg::LEVEL_W-1:0]  level,
    output dda3_pkg::move_info_t          info
);
    import dda3_pkg::*;

    count_t mx_ab;
    count_t mx;
    event_t limit;

    always_comb
    begin
        mx_ab = (steps[1] > steps[0]) ? steps[1] : steps[0];
        mx    = (steps[2] > mx_ab) ? steps[2] : mx_ab;
        limit = EVENT_LIMIT >> level[1:0];
        info.ok = (mx != '0) && (level <= LEVEL_MAX) && (mx <= {2'b00, limit});
        info.total = mx[EVENT_W-1:0] << level[1:0];
    end

endmodule

@@ rtl/dda3_axis.sv @@
// ----------------------------------------------------------------------------
// dda3_axis
// Error accumulator and increment of one axis; flags a step on each tick.
// ----------------------------------------------------------------------------
module dda3_axis (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dda3_pkg::axis_ctl_t  ctl,
    input  dda3_pkg::count_t     count,
    output logic                 step
);
    import dda3_pkg::*;

    logic [ERR_W-1:0]   err_reg;
    logic [ERR_W-1:0]   err_next;
    logic [INC_W-1:0]   inc_reg;
    logic [INC_W-1:0]   inc_next;
    logic [ERR_W+1:0]   sum;
    logic [ERR_W+1:0]   diff;

    always_comb
    begin
        sum  = {{2{err_reg[ERR_W-1]}}, err_reg} + {3'b000, inc_reg};
        diff = sum - {3'b000, ctl.wrap};
        step = !sum[ERR_W+1];
        err_next = err_reg;
        inc_next = inc_reg;
        if (ctl.load)
        begin
            err_next = ERR_W'(-{2'b00, ctl.total});
            inc_next = {count[INC_W-2:0], 1'b0};
        end
        else if (ctl.tick)
        begin
            err_next = step ? diff[ERR_W-1:0] : sum[ERR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= '0;
            inc_reg <= '0;
        end
        else
        begin
            err_reg <= err_next;
            inc_reg <= inc_next;
        end
    end

endmodule

@@ rtl/three_axis_dda_step_generator.sv @@
// ----------------------------------------------------------------------------
// three_axis_dda_step_generator
// Three-axis Bresenham DDA step generator with a smoothing multiplier.
// ----------------------------------------------------------------------------
// Usage: each input transaction is either a start (tuser = 0), carrying the
// step counts of axes A, B and C and a smoothing level, or a tick
// (tuser = 1). A start loads a new move, discarding any move in progress,
// or rejects it when all counts are zero, the level is above three or the
// scaled count does not fit in 30 bits. Every tick of an active move
// advances the three error accumulators and reports which axes step.
// Every input transaction yields exactly one output transaction with the
// step mask, the accept flag, the busy flag and the events left.
// An item passes the input register and then the output register. One
// transaction per clock is sustained while the receiver keeps tready high,
// as the accumulators update in the same cycle that the result is
// registered. When the receiver stalls, the output register holds and the
// input register fills, then tready drops. Reset clears the valid flags,
// move counters and axis accumulators, so the block starts idle.
// ----------------------------------------------------------------------------
module three_axis_dda_step_generator (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // steps_a[31:0], steps_b[63:32], steps_c[95:64], smooth_shift[98:96]
    input  logic [103:0]  s_axis_tdata,
    // op[0]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // step_mask[2:0], accepted[3], busy_res[4], events_left[34:5]
    output logic [39:0]   m_axis_tdata
);
    import dda3_pkg::*;

    logic                in_valid_reg;
    logic                op_reg;
    count_t              steps_reg [AXES];
    logic [LEVEL_W-1:0]  level_reg;

    logic                out_valid_reg;
    logic [AXES-1:0]     mask_reg;
    logic [AXES-1:0]     mask_next;
    logic                acc_reg;
    logic                acc_next;
    logic                busy_reg;
    logic                busy_next;
    event_t              left_reg;
    event_t              left_next;

    event_t              total_reg;
    event_t              total_next;
    event_t              done_reg;
    event_t              done_next;
    logic [INC_W-1:0]    wrap_reg;
    logic [INC_W-1:0]    wrap_next;

    logic                advance;
    logic                active;
    logic                start;
    logic                tick;
    move_info_t          info;
    axis_ctl_t           ctl;
    logic [AXES-1:0]     step;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign active        = done_reg < total_reg;
    assign start         = advance && (op_reg == OP_START);
    assign tick          = advance && (op_reg == OP_TICK) && active;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg       <= s_axis_tuser;
            steps_reg[0] <= s_axis_tdata[31:0];
            steps_reg[1] <= s_axis_tdata[63:32];
            steps_reg[2] <= s_axis_tdata[95:64];
            level_reg    <= s_axis_tdata[98:96];
        end
    end

    dda3_move u_move (
        .steps (steps_reg),
        .level (level_reg),
        .info  (info)
    );

    always_comb
    begin
        ctl.load  = start && info.ok;
        ctl.tick  = tick;
        ctl.total = info.total;
        ctl.wrap  = wrap_reg;
    end

    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        dda3_axis u_axis (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .count (steps_reg[g]),
            .step  (step[g])
        );
    end

    always_comb
    begin
        total_next = total_reg;
        done_next  = done_reg;
        wrap_next  = wrap_reg;
        if (start)
        begin
            total_next = info.ok ? info.total : '0;
            done_next  = '0;
            if (info.ok)
            begin
                wrap_next = {info.total, 1'b0};
            end
        end
        else if (tick)
        begin
            done_next = done_reg + 1'b1;
        end
        mask_next = tick ? step : '0;
        acc_next  = start && info.ok;
        busy_next = start ? info.ok : (tick ? (done_next != total_reg) : active);
        left_next = total_next - done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            done_reg      <= '0;
            wrap_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            done_reg  <= done_next;
            wrap_reg  <= wrap_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg <= mask_next;
            acc_reg  <= acc_next;
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, left_reg, busy_reg, acc_reg, mask_reg};

endmodule

@@ tb/tb_three_axis_dda_step_generator.sv @@
// ----------------------------------------------------------------------------
// tb_three_axis_dda_step_generator
// Self-checking testbench for the three-axis DDA step generator.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the move state (error
// accumulators, increments, wrap amount, event counters). It predicts the
// result of every accepted input transaction and checks each output
// transaction against the oldest prediction, field by field. Stimulus
// starts with directed boundary starts and idle ticks. It then runs random
// well-formed moves with ticks, mixed with rejected starts and restarts.
// Both stream sides idle at random. The receiver also holds off once for a
// long stretch, and the sender pauses now and then until all results are in.
// ----------------------------------------------------------------------------
module tb_three_axis_dda_step_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import dda3_pkg::*;

    localparam int RES_W      = 40;
    localparam int LONG_HOLD  = 80;
    localparam int ITEM_COUNT = 800;

    class dda_step_scoreboard;
        logic signed [ERR_W-1:0] axis_err [AXES];
        logic [INC_W-1:0]        axis_inc [AXES];
        logic [INC_W-1:0]        wrap;
        event_t                  total;
        event_t                  done;
        logic [RES_W-1:0]        pending_results [$];

        function new();
            for (int i = 0; i < AXES; i++)
            begin
                axis_err[i] = '0;
                axis_inc[i] = '0;
            end
            wrap  = '0;
            total = '0;
            done  = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_item(logic op, count_t ca, count_t cb, count_t cc,
                                logic [LEVEL_W-1:0] lvl);
            count_t                  cnt [AXES];
            count_t                  peak;
            logic [2:0]              mask;
            logic                    acc;
            logic signed [ERR_W+1:0] sum;
            event_t                  left;
            cnt[0] = ca;
            cnt[1] = cb;
            cnt[2] = cc;
            mask = '0;
            acc  = 1'b0;
            if (op == OP_START)
            begin
                peak = cnt[0];
                if (cnt[1] > peak) peak = cnt[1];
                if (cnt[2] > peak) peak = cnt[2];
                done = '0;
                if (peak == 0 || lvl > LEVEL_MAX ||
                    peak > (count_t'(EVENT_LIMIT) >> lvl))
                begin
                    total = '0;
                end
                else
                begin
                    total = event_t'(peak << lvl);
                    wrap  = {total, 1'b0};
                    for (int i = 0; i < AXES; i++)
                    begin
                        axis_err[i] = -$signed({2'b00, total});
                        axis_inc[i] = {cnt[i][EVENT_W-1:0], 1'b0};
                    end
                    acc = 1'b1;
                end
            end
            else if (done < total)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    sum = axis_err[i] + $signed({3'b000, axis_inc[i]});
                    if (!sum[ERR_W+1])
                    begin
                        mask[i] = 1'b1;
                        sum = sum - $signed({3'b000, wrap});
                    end
                    axis_err[i] = sum[ERR_W-1:0];
                end
                done = done + 1'b1;
            end
            left = total - done;
            pending_results.push_back({5'b0, left, (done < total), acc, mask});
        endfunction

        function bit check_step(logic [RES_W-1:0] got, output string msg);
            logic [RES_W-1:0] want;
            msg = "";
            if (pending_results.size() == 0)
            begin
                msg = $sformatf("result %h arrived with none expected", got);
                return 1'b0;
            end
            want = pending_results.pop_front();
            if (got[2:0] !== want[2:0])
                msg = {msg, $sformatf(" step_mask %b/%b", got[2:0], want[2:0])};
            if (got[3] !== want[3])
                msg = {msg, $sformatf(" accepted %b/%b", got[3], want[3])};
            if (got[4] !== want[4])
                msg = {msg, $sformatf(" busy %b/%b", got[4], want[4])};
            if (got[34:5] !== want[34:5])
                msg = {msg, $sformatf(" events_left %h/%h", got[34:5], want[34:5])};
            if (msg != "")
                msg = {"got/exp:", msg};
            return msg == "";
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;

    dda_step_scoreboard sb;
    int  mismatches = 0;
    int  items_sent = 0;
    bit  hold_req = 1'b0;

    three_axis_dda_step_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= 50)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic send_item(logic op, count_t ca, count_t cb, count_t cc,
                             logic [LEVEL_W-1:0] lvl);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, lvl, cc, cb, ca};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(op, ca, cb, cc, lvl);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, $urandom, $urandom, $urandom, LEVEL_W'($urandom));
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned ready_run;
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= 1'b1;
            ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 6);
            repeat (ready_run) @(posedge clk);
            gap = gap_len();
            if (gap > 0 && !hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            if (!sb.check_step(m_axis_tdata, msg))
                report_mismatch(msg);
    end

    initial
    begin
        count_t      cnt [AXES];
        count_t      peak;
        logic [2:0]  lvl;
        int unsigned n_ticks;
        int unsigned kind;
        bit          held;
        bit          drained;
        held    = 1'b0;
        drained = 1'b0;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_tick();
        send_item(OP_START, 0, 0, 0, 3'd0);
        send_item(OP_START, 1, 1, 1, 3'd4);
        send_item(OP_START, 5, 0, 2, 3'd7);
        send_item(OP_START, 32'h3FFF_FFFF, 1, 0, 3'd0);
        repeat (3) send_tick();
        send_item(OP_START, 32'h4000_0000, 0, 0, 3'd0);
        send_item(OP_START, 32'h07FF_FFFF, 1, 32'h07FF_FFFF, 3'd3);
        repeat (2) send_tick();
        send_item(OP_START, 0, 0, 32'h0800_0000, 3'd3);
        send_item(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0);
        send_item(OP_START, 3, 2, 1, 3'd1);
        repeat (7) send_tick();
        send_item(OP_START, 5, 0, 0, 3'd2);
        repeat (2) send_tick();
        send_item(OP_START, 0, 2, 7, 3'd0);
        send_tick();

        while (items_sent < ITEM_COUNT)
        begin
            if (!held && items_sent >= 250)
            begin
                held = 1'b1;
                hold_req = 1'b1;
            end
            if (!hold_req &&
                ((!drained && items_sent >= 500) || $urandom_range(0, 19) == 0))
            begin
                drained = 1'b1;
                wait_for_drain();
            end
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                lvl = LEVEL_W'($urandom_range(0, 3));
                if ($urandom_range(0, 4) == 0)
                    peak = $urandom_range(1, 32'h3FFF_FFFF >> lvl);
                else
                    peak = $urandom_range(1, 12);
                for (int i = 0; i < AXES; i++)
                    cnt[i] = $urandom_range(0, peak);
                cnt[2'($urandom_range(0, AXES - 1))] = peak;
                send_item(OP_START, cnt[0], cnt[1], cnt[2], lvl);
                if (peak > 12)
                    n_ticks = $urandom_range(5, 40);
                else if ($urandom_range(0, 3) == 0)
                    n_ticks = $urandom_range(0, peak << lvl);
                else
                    n_ticks = (peak << lvl) + $urandom_range(0, 3);
                repeat (n_ticks) send_tick();
            end
            else if (kind < 80)
            begin
                send_item(OP_START, $urandom, $urandom, $urandom, LEVEL_W'($urandom));
            end
            else if (kind < 86)
            begin
                lvl = LEVEL_W'($urandom_range(0, 3));
                peak = (32'h3FFF_FFFF >> lvl) + $urandom_range(1, 1000);
                send_item(OP_START, $urandom_range(0, 32'h3FFF_FFFF >> lvl), peak,
                          $urandom_range(0, 100), lvl);
            end
            else if (kind < 92)
            begin
                send_item(OP_START, $urandom_range(1, 20), $urandom_range(0, 20),
                          $urandom_range(0, 20), LEVEL_W'($urandom_range(4, 7)));
            end
            else if (kind < 96)
            begin
                send_item(OP_START, 0, 0, 0, LEVEL_W'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_tick();
            end
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/dda3_pkg.sv
rtl/dda3_move.sv
rtl/dda3_axis.sv
rtl/three_axis_dda_step_generator.sv
tb/tb_three_axis_dda_step_generator.sv
